@@ design/mss_pkg.sv @@
// Shared widths, run summary and result types for the masked sample statistics block.
package mss_pkg;

    // Field and accumulator widths.
    localparam int SAMPLE_W = 16;
    localparam int COUNT_W  = 17;
    localparam int SUM_W    = 33;
    localparam int SQSUM_W  = 47;
    localparam int MAG_W    = 32;
    localparam int ROOT_W   = 16;

    // Divider operand widths: N*sumsq fits in 63 bits, N*(N-1) in 32 bits.
    localparam int NUM_W = 63;
    localparam int DEN_W = 32;

    // The N*sumsq product is built from two partial products split at this bit.
    localparam int SQ_SPLIT = 24;

    // Number of finished runs that can wait between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    // Result word and its padding to whole bytes.
    localparam int RESULT_W  = COUNT_W + 4 * SAMPLE_W;
    localparam int M_TDATA_W = ((RESULT_W + 7) / 8) * 8;

    // Totals of one finished run, handed from the accumulator to the back end.
    typedef struct packed {
        logic        [COUNT_W-1:0]  count;
        logic signed [SUM_W-1:0]    sum;
        logic        [SQSUM_W-1:0]  sqsum;
        logic signed [SAMPLE_W-1:0] min_val;
        logic signed [SAMPLE_W-1:0] max_val;
    } run_summary_t;

    // One result word; the count sits in the lowest bits.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] max_val;
        logic signed [SAMPLE_W-1:0] min_val;
        logic        [ROOT_W-1:0]   std_dev;
        logic signed [SAMPLE_W-1:0] mean;
        logic        [COUNT_W-1:0]  count;
    } result_t;

endpackage

@@ design/mss_front.sv @@
// Sample accumulator: one word per cycle unless the queue is full; pushes finished runs.
module mss_front
    import mss_pkg::*;
#(
    parameter int MAX_SAMPLES = 65536
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [SAMPLE_W-1:0] s_tdata,   // [15:0] sample_value
    input  logic                s_tuser,   // [0] present
    input  logic                s_tlast,
    input  logic                q_full,
    output logic                push,
    output run_summary_t        push_data
);

    localparam logic [COUNT_W-1:0] COUNT_CAP =
        (MAX_SAMPLES < 65536) ? COUNT_W'(MAX_SAMPLES) : COUNT_W'(65536);

    logic        [COUNT_W-1:0]    count_reg, count_next;
    logic signed [SUM_W-1:0]      sum_reg, sum_next;
    logic        [SQSUM_W-1:0]    sqsum_reg, sqsum_next;
    logic signed [SAMPLE_W-1:0]   min_reg, min_next;
    logic signed [SAMPLE_W-1:0]   max_reg, max_next;

    logic                         accept;
    logic                         take;
    logic signed [SAMPLE_W-1:0]   sample;
    logic signed [2*SAMPLE_W-1:0] square;
    run_summary_t                 upd;

    // A word can enter whenever the queue has room for a finished run.
    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign sample   = $signed(s_tdata);
    assign square   = sample * sample;

    // Present samples count until the run reaches its cap.
    assign take = accept && s_tuser && (count_reg < COUNT_CAP);

    // Totals including the current word.
    always_comb begin
        upd.count   = count_reg;
        upd.sum     = sum_reg;
        upd.sqsum   = sqsum_reg;
        upd.min_val = min_reg;
        upd.max_val = max_reg;
        if (take) begin
            upd.count = count_reg + 1'b1;
            upd.sum   = sum_reg + SUM_W'(sample);
            upd.sqsum = sqsum_reg + SQSUM_W'($unsigned(square));
            if (sample < min_reg) begin
                upd.min_val = sample;
            end
            if (sample > max_reg) begin
                upd.max_val = sample;
            end
        end
    end

    // The last word of a run pushes its totals and clears the accumulators.
    assign push      = accept && s_tlast;
    assign push_data = upd;

    always_comb begin
        count_next = upd.count;
        sum_next   = upd.sum;
        sqsum_next = upd.sqsum;
        min_next   = upd.min_val;
        max_next   = upd.max_val;
        if (push) begin
            count_next = '0;
            sum_next   = '0;
            sqsum_next = '0;
            min_next   = {1'b0, {(SAMPLE_W-1){1'b1}}};
            max_next   = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            sum_reg   <= '0;
            sqsum_reg <= '0;
            min_reg   <= {1'b0, {(SAMPLE_W-1){1'b1}}};
            max_reg   <= {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            count_reg <= count_next;
            sum_reg   <= sum_next;
            sqsum_reg <= sqsum_next;
            min_reg   <= min_next;
            max_reg   <= max_next;
        end
    end

endmodule

@@ design/mss_queue.sv @@
// Short queue of finished run totals between the accumulator and the back end.
module mss_queue
    import mss_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  run_summary_t push_data,
    output logic         full,
    input  logic         pop,
    output logic         not_empty,
    output run_summary_t head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

    run_summary_t       entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic               do_push;
    logic               do_pop;

    assign full      = (fill_reg == FILL_W'(QUEUE_DEPTH));
    assign not_empty = (fill_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    // Pointer and fill bookkeeping.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({do_push, do_pop})
            2'b10:   fill_next = fill_reg + 1'b1;
            2'b01:   fill_next = fill_reg - 1'b1;
            default: fill_next = fill_reg;
        endcase
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

@@ design/mss_divider.sv @@
// Restoring divider that produces one quotient bit per cycle.
module mss_divider
    import mss_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic             done,
    output logic [NUM_W-1:0] quotient
);

    localparam int STEP_W = $clog2(NUM_W);

    typedef enum logic {
        DIV_IDLE,
        DIV_RUN
    } div_state_t;

    div_state_t         state_reg, state_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [DEN_W:0]     rem_reg, rem_next;
    logic [NUM_W-1:0]   dq_reg, dq_next;
    logic [DEN_W-1:0]   divisor_reg, divisor_next;
    logic               done_reg, done_next;

    logic [DEN_W:0]     rem_shift;
    logic [DEN_W:0]     rem_diff;
    logic               fits;

    // One trial subtraction per cycle; the dividend shifts out as quotient bits shift in.
    assign rem_shift = {rem_reg[DEN_W-1:0], dq_reg[NUM_W-1]};
    assign rem_diff  = rem_shift - {1'b0, divisor_reg};
    assign fits      = (rem_shift >= {1'b0, divisor_reg});

    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        rem_next     = rem_reg;
        dq_next      = dq_reg;
        divisor_next = divisor_reg;
        done_next    = 1'b0;
        unique case (state_reg)
            DIV_IDLE: begin
                if (start) begin
                    dq_next      = dividend;
                    divisor_next = divisor;
                    rem_next     = '0;
                    step_next    = STEP_W'(NUM_W - 1);
                    state_next   = DIV_RUN;
                end
            end
            DIV_RUN: begin
                rem_next = fits ? rem_diff : rem_shift;
                dq_next  = {dq_reg[NUM_W-2:0], fits};
                if (step_reg == '0) begin
                    done_next  = 1'b1;
                    state_next = DIV_IDLE;
                end else begin
                    step_next = step_reg - 1'b1;
                end
            end
            default: state_next = DIV_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        step_reg    <= step_next;
        rem_reg     <= rem_next;
        dq_reg      <= dq_next;
        divisor_reg <= divisor_next;
        if (!aresetn) begin
            state_reg <= DIV_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign done     = done_reg;
    assign quotient = dq_reg;

endmodule

@@ design/mss_back.sv @@
// Back end: turns run totals into mean, deviation, minimum and maximum.
module mss_back
    import mss_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_valid,
    input  run_summary_t     head,
    output logic             pop,
    output logic             div_start,
    output logic [NUM_W-1:0] div_dividend,
    output logic [DEN_W-1:0] div_divisor,
    input  logic             div_done,
    input  logic [NUM_W-1:0] div_quotient,
    output logic             out_valid,
    input  logic             out_ready,
    output result_t          out_result
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_SQUARE,
        ST_NUM,
        ST_MEAN_GO,
        ST_MEAN_WAIT,
        ST_VAR_GO,
        ST_VAR_WAIT,
        ST_ROOT,
        ST_FINISH
    } back_state_t;

    localparam int LO_PROD_W = COUNT_W + SQ_SPLIT;
    localparam int HI_PROD_W = COUNT_W + SQSUM_W - SQ_SPLIT;

    back_state_t                state_reg, state_next;
    logic        [COUNT_W-1:0]  cnt_reg, cnt_next;
    logic                       neg_reg, neg_next;
    logic        [MAG_W-1:0]    mag_reg, mag_next;
    logic        [SQSUM_W-1:0]  sqsum_reg, sqsum_next;
    logic signed [SAMPLE_W-1:0] min_reg, min_next;
    logic signed [SAMPLE_W-1:0] max_reg, max_next;
    logic        [NUM_W-1:0]    prod_reg, prod_next;
    logic        [NUM_W-1:0]    magsq_reg, magsq_next;
    logic        [DEN_W-1:0]    den_reg, den_next;
    logic        [NUM_W-1:0]    num_reg, num_next;
    logic        [SAMPLE_W-1:0] mean_reg, mean_next;
    logic        [NUM_W-1:0]    var_reg, var_next;
    logic        [ROOT_W-1:0]   root_reg, root_next;
    logic        [ROOT_W-1:0]   bit_reg, bit_next;
    logic                       out_valid_reg, out_valid_next;
    result_t                    out_reg, out_next;

    logic        [SUM_W-1:0]         abs_sum;
    logic        [LO_PROD_W-1:0]     mul_lo;
    logic        [HI_PROD_W-1:0]     mul_hi;
    logic        [HI_PROD_W+SQ_SPLIT-1:0] hi_shift;
    logic        [2*MAG_W-1:0]       mag_sq_full;
    logic        [2*COUNT_W-1:0]     den_full;
    logic        [ROOT_W-1:0]        trial;
    logic        [2*ROOT_W-1:0]      trial_sq;

    // Datapath: each multiplier but the root trial square feeds a register.
    assign abs_sum     = head.sum[SUM_W-1] ? SUM_W'(-head.sum) : SUM_W'(head.sum);
    assign mul_lo      = cnt_reg * sqsum_reg[SQ_SPLIT-1:0];
    assign mul_hi      = cnt_reg * sqsum_reg[SQSUM_W-1:SQ_SPLIT];
    assign hi_shift    = {mul_hi, {SQ_SPLIT{1'b0}}};
    assign mag_sq_full = mag_reg * mag_reg;
    assign den_full    = cnt_reg * (cnt_reg - 1'b1);
    assign trial       = root_reg | bit_reg;
    assign trial_sq    = trial * trial;

    // The shared divider is started for the mean and then for the variance.
    assign pop          = (state_reg == ST_IDLE) && q_valid;
    assign div_start    = (state_reg == ST_MEAN_GO) || (state_reg == ST_VAR_GO);
    assign div_dividend = (state_reg == ST_MEAN_GO) ? NUM_W'(mag_reg) : num_reg;
    assign div_divisor  = (state_reg == ST_MEAN_GO) ? DEN_W'(cnt_reg) : den_reg;

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        neg_next       = neg_reg;
        mag_next       = mag_reg;
        sqsum_next     = sqsum_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        prod_next      = prod_reg;
        magsq_next     = magsq_reg;
        den_next       = den_reg;
        num_next       = num_reg;
        mean_next      = mean_reg;
        var_next       = var_reg;
        root_next      = root_reg;
        bit_next       = bit_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    cnt_next   = head.count;
                    neg_next   = head.sum[SUM_W-1];
                    mag_next   = abs_sum[MAG_W-1:0];
                    sqsum_next = head.sqsum;
                    min_next   = head.min_val;
                    max_next   = head.max_val;
                    // Below two samples the mean is the sum and the deviation is zero.
                    mean_next  = head.sum[SAMPLE_W-1:0];
                    root_next  = '0;
                    state_next = (head.count < COUNT_W'(2)) ? ST_FINISH : ST_MUL_LO;
                end
            end
            ST_MUL_LO: begin
                prod_next  = NUM_W'(mul_lo);
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI: begin
                prod_next  = prod_reg + hi_shift[NUM_W-1:0];
                state_next = ST_SQUARE;
            end
            ST_SQUARE: begin
                magsq_next = mag_sq_full[NUM_W-1:0];
                den_next   = den_full[DEN_W-1:0];
                state_next = ST_NUM;
            end
            ST_NUM: begin
                num_next   = prod_reg - magsq_reg;
                state_next = ST_MEAN_GO;
            end
            ST_MEAN_GO: begin
                state_next = ST_MEAN_WAIT;
            end
            ST_MEAN_WAIT: begin
                if (div_done) begin
                    // Truncation toward zero: divide the magnitude, then restore the sign.
                    mean_next  = neg_reg ? SAMPLE_W'(-div_quotient[SAMPLE_W-1:0])
                                         : div_quotient[SAMPLE_W-1:0];
                    state_next = ST_VAR_GO;
                end
            end
            ST_VAR_GO: begin
                state_next = ST_VAR_WAIT;
            end
            ST_VAR_WAIT: begin
                if (div_done) begin
                    var_next   = div_quotient;
                    root_next  = '0;
                    bit_next   = {1'b1, {(ROOT_W-1){1'b0}}};
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT: begin
                // Integer square root, one result bit per cycle from the top.
                if (NUM_W'(trial_sq) <= var_reg) begin
                    root_next = trial;
                end
                bit_next = bit_reg >> 1;
                if (bit_reg[0]) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!out_valid_reg || out_ready) begin
                    out_next.count   = cnt_reg;
                    out_next.mean    = $signed(mean_reg);
                    out_next.std_dev = root_reg;
                    out_next.min_val = min_reg;
                    out_next.max_val = max_reg;
                    out_valid_next   = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        cnt_reg   <= cnt_next;
        neg_reg   <= neg_next;
        mag_reg   <= mag_next;
        sqsum_reg <= sqsum_next;
        min_reg   <= min_next;
        max_reg   <= max_next;
        prod_reg  <= prod_next;
        magsq_reg <= magsq_next;
        den_reg   <= den_next;
        num_reg   <= num_next;
        mean_reg  <= mean_next;
        var_reg   <= var_next;
        root_reg  <= root_next;
        bit_reg   <= bit_next;
        out_reg   <= out_next;
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;

endmodule

@@ design/masked_sample_statistics_unit.sv @@
// Masked sample statistics: per-run count, mean, deviation, minimum and maximum.
//
// Input words carry a 16-bit signed sample in s_tdata, a present flag in s_tuser and
// the end of a run in s_tlast. Present samples are accumulated at one word per cycle
// while the queue has room; absent ones are skipped, but their s_tlast still closes
// the run. Once a run holds the lesser of MAX_SAMPLES and 65536 samples, further
// present samples are ignored. Each run produces one result word on m_tdata: count,
// mean (truncated toward zero), sample standard deviation (truncated integer root),
// minimum and maximum. Runs with fewer than two samples report the sum as mean and a
// zero deviation. A closed run waits in a two-entry queue for the back end. A run of
// fewer than two samples goes straight to the result; any other run takes two passes
// through the shared one-bit-per-cycle divider (63 steps each) and the 16-step root.
// The result then sits in an output register until m_tready takes it, while the back
// end already works on the next run. s_tready drops only while the queue is full.
// Reset clears the accumulators, empties the queue and clears the output valid flag.
module masked_sample_statistics_unit
    import mss_pkg::*;
#(
    parameter int MAX_SAMPLES = 65536
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [SAMPLE_W-1:0]  s_tdata,   // [15:0] sample_value
    input  logic                 s_tuser,   // [0] present
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // [16:0] sample_count, [32:17] mean,
                                            // [48:33] std_dev, [64:49] minimum,
                                            // [80:65] maximum, [87:81] zero
);

    logic             push;
    run_summary_t     push_data;
    logic             q_full;
    logic             q_valid;
    logic             pop;
    run_summary_t     head;
    logic             div_start;
    logic [NUM_W-1:0] div_dividend;
    logic [DEN_W-1:0] div_divisor;
    logic             div_done;
    logic [NUM_W-1:0] div_quotient;
    result_t          m_result;

    mss_front #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    mss_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_valid),
        .head      (head)
    );

    mss_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    mss_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .head         (head),
        .pop          (pop),
        .div_start    (div_start),
        .div_dividend (div_dividend),
        .div_divisor  (div_divisor),
        .div_done     (div_done),
        .div_quotient (div_quotient),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_result   (m_result)
    );

    assign m_tdata = {{(M_TDATA_W-RESULT_W){1'b0}}, m_result};

`ifndef SYNTH
    // A closing word is never taken while the queue has no room for its run.
    a_queue_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_full)
        else $error("run pushed into a full queue");

    // Runs of fewer than two samples report a zero deviation.
    a_short_run_no_dev: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_result.count < COUNT_W'(2)) |-> (m_result.std_dev == '0))
        else $error("nonzero deviation for a short run");

    // A nonempty run has its minimum at or below its maximum.
    a_min_le_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_result.count != '0) |-> (m_result.min_val <= m_result.max_val))
        else $error("minimum above maximum");

    // The reported count never passes the run cap.
    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_result.count <=
            ((MAX_SAMPLES < 65536) ? COUNT_W'(MAX_SAMPLES) : COUNT_W'(65536))))
        else $error("count above the run cap");
`endif

endmodule
